// ----- rtl/stt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, error codes and the result record passed front to back.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned KindW = 6;
  localparam int unsigned ErrW  = 3;
  localparam int unsigned LenW  = 16;
  localparam int unsigned IvalW = 31;

  localparam logic [KindW-1:0] K_END    = 6'd0;
  localparam logic [KindW-1:0] K_IDENT  = 6'd1;
  localparam logic [KindW-1:0] K_FN     = 6'd2;
  localparam logic [KindW-1:0] K_LET    = 6'd3;
  localparam logic [KindW-1:0] K_IF     = 6'd4;
  localparam logic [KindW-1:0] K_ELSE   = 6'd5;
  localparam logic [KindW-1:0] K_RETURN = 6'd6;
  localparam logic [KindW-1:0] K_BOOL   = 6'd7;
  localparam logic [KindW-1:0] K_INT    = 6'd8;
  localparam logic [KindW-1:0] K_DEC    = 6'd9;
  localparam logic [KindW-1:0] K_CHAR   = 6'd10;
  localparam logic [KindW-1:0] K_STR    = 6'd11;
  localparam logic [KindW-1:0] K_SBYTE  = 6'd12;
  localparam logic [KindW-1:0] K_PLUS   = 6'd13;
  localparam logic [KindW-1:0] K_MINUS  = 6'd14;
  localparam logic [KindW-1:0] K_STAR   = 6'd15;
  localparam logic [KindW-1:0] K_SLASH  = 6'd16;
  localparam logic [KindW-1:0] K_LPAR   = 6'd17;
  localparam logic [KindW-1:0] K_RPAR   = 6'd18;
  localparam logic [KindW-1:0] K_LBRACE = 6'd19;
  localparam logic [KindW-1:0] K_RBRACE = 6'd20;
  localparam logic [KindW-1:0] K_LBRK   = 6'd21;
  localparam logic [KindW-1:0] K_RBRK   = 6'd22;
  localparam logic [KindW-1:0] K_COMMA  = 6'd23;
  localparam logic [KindW-1:0] K_SEMI   = 6'd24;
  localparam logic [KindW-1:0] K_COLON  = 6'd25;
  localparam logic [KindW-1:0] K_ASSIGN = 6'd26;
  localparam logic [KindW-1:0] K_NOT    = 6'd28;
  localparam logic [KindW-1:0] K_LT     = 6'd30;
  localparam logic [KindW-1:0] K_GT     = 6'd32;
  localparam logic [KindW-1:0] K_ERROR  = 6'd34;

  localparam logic [ErrW-1:0] E_NONE     = 3'd0;
  localparam logic [ErrW-1:0] E_BADCHAR  = 3'd1;
  localparam logic [ErrW-1:0] E_OPENCHAR = 3'd2;
  localparam logic [ErrW-1:0] E_OPENESC  = 3'd3;
  localparam logic [ErrW-1:0] E_NOQUOTE  = 3'd4;
  localparam logic [ErrW-1:0] E_OPENSTR  = 3'd5;

  localparam int unsigned MaxRes = 3;

  // 16 bit positions on the ports; internal counters may be wider/narrower
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ErrW-1:0]  err;
    logic [15:0]      line;
    logic [15:0]      col;
    logic [IvalW-1:0] ival;
    logic             ovf;
    logic [7:0]       byte_v;
    logic             bval;
    logic [LenW-1:0]  len;
  } tok_t;

  // one transaction's worth of results
  typedef struct packed {
    logic [1:0]  n;
    tok_t [2:0]  r;
  } bundle_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == 8'h6e) r = 8'd10;
    else if (b == 8'h74) r = 8'd9;
    else if (b == 8'h72) r = 8'd13;
    else if (b == 8'h30) r = 8'd0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/stt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_front: scanner
// Classifies each byte, keeps the scan state and forms up to three results.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned INT_BITS      = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  byte_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output bundle_t          q_data_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_DECIMAL, M_SLASH, M_COMMENT, M_OP,
    M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE, M_STRING, M_STRING_ESC
  } mode_e;

  localparam logic [POSITION_BITS-1:0] PosLim = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam int unsigned AccW = INT_BITS - 1;
  localparam logic [AccW-1:0] IntLim = {AccW{1'b1}};
  localparam logic [LenW-1:0] LenLim = {LenW{1'b1}};

  mode_e mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d, tline_q, tline_d, tcol_q, tcol_d;
  logic [LenW-1:0] tlen_q, tlen_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic ovf_q, ovf_d, kwlong_q, kwlong_d, halt_q, halt_d;
  logic [47:0] kw_q, kw_d;
  logic [7:0] pend_q, pend_d;
  bundle_t out_d;

  logic fire;
  assign in_ready_o = q_ready_i;
  assign fire = in_valid_i && q_ready_i;
  assign q_valid_o = fire && (out_d.n != 2'd0);
  assign q_data_o = out_d;

  // ports carry the low 16 bits of a position
  function automatic logic [15:0] p16(input logic [POSITION_BITS-1:0] v);
    return 16'(v);
  endfunction

  function automatic logic [POSITION_BITS-1:0] pinc(input logic [POSITION_BITS-1:0] v);
    return (v == PosLim) ? v : v + PosOne;
  endfunction

  function automatic logic [LenW-1:0] linc(input logic [LenW-1:0] v);
    return (v == LenLim) ? v : v + 1'b1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // appended result of the current step
  tok_t res [MaxRes];
  logic [1:0] cnt;

  logic [AccW+3:0] acc_x10;
  logic [AccW+3:0] acc_sum;
  always_comb begin
    acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
    acc_sum = acc_x10 + (AccW+4)'(byte_i - 8'h30);
  end

  // keyword match on packed buffer
  logic [KindW-1:0] id_kind;
  logic id_bool;
  always_comb begin
    id_kind = K_IDENT;
    id_bool = 1'b0;
    if (!kwlong_q) begin
      if (kw_q == 48'h666e) id_kind = K_FN;
      else if (kw_q == 48'h6c6574) id_kind = K_LET;
      else if (kw_q == 48'h6966) id_kind = K_IF;
      else if (kw_q == 48'h656c7365) id_kind = K_ELSE;
      else if (kw_q == 48'h72657475726e) id_kind = K_RETURN;
      else if (kw_q == 48'h74727565) begin
        id_kind = K_BOOL; id_bool = 1'b1;
      end else if (kw_q == 48'h66616c7365) id_kind = K_BOOL;
    end
  end

  logic [IvalW-1:0] acc_out;
  assign acc_out = IvalW'(acc_q);

  always_comb begin
    tok_t t;
    logic repro, emitted;
    logic [7:0] b;
    t = '0;
    repro = 1'b0;
    emitted = 1'b0;
    b = byte_i;
    mode_d = mode_q; line_d = line_q; col_d = col_q; tline_d = tline_q; tcol_d = tcol_q;
    tlen_d = tlen_q; acc_d = acc_q; ovf_d = ovf_q; kwlong_d = kwlong_q; halt_d = halt_q;
    kw_d = kw_q; pend_d = pend_q;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;
    cnt = 2'd0;

    if (cmd_i) begin
      // flush pending token
      t = '0; t.line = p16(tline_q); t.col = p16(tcol_q); t.len = tlen_q;
      unique case (mode_q)
        M_IDENT: begin t.kind = id_kind; t.bval = id_bool; res[0] = t; cnt = 2'd1; end
        M_INT: begin t.kind = K_INT; t.ival = acc_out; t.ovf = ovf_q; res[0] = t; cnt = 2'd1; end
        M_INT_DOT: begin
          t.kind = K_INT; t.ival = acc_out; t.ovf = ovf_q; res[0] = t;
          t = '0; t.kind = K_ERROR; t.err = E_BADCHAR; t.line = p16(line_q);
          t.col = p16(col_q); res[1] = t; cnt = 2'd2;
        end
        M_DECIMAL: begin t.kind = K_DEC; res[0] = t; cnt = 2'd1; end
        M_SLASH: begin t.kind = K_SLASH; t.len = 16'd1; res[0] = t; cnt = 2'd1; end
        M_OP: begin t.kind = pend_q[KindW-1:0]; t.len = 16'd1; res[0] = t; cnt = 2'd1; end
        M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE, M_STRING, M_STRING_ESC: begin
          t = '0; t.kind = K_ERROR; t.line = p16(line_q); t.col = p16(col_q);
          t.err = (mode_q == M_CHAR_OPEN) ? E_OPENCHAR :
                  (mode_q == M_CHAR_ESC) ? E_OPENESC :
                  (mode_q == M_CHAR_CLOSE) ? E_NOQUOTE : E_OPENSTR;
          res[0] = t; cnt = 2'd1;
        end
        default: ;
      endcase
      t = '0; t.kind = K_END; t.line = p16(line_q); t.col = p16(col_q);
      res[cnt] = t; cnt = cnt + 2'd1;
      mode_d = M_IDLE; line_d = PosOne; col_d = PosOne; tline_d = PosOne; tcol_d = PosOne;
      tlen_d = '0; acc_d = '0; ovf_d = 1'b0; kwlong_d = 1'b0; halt_d = 1'b0;
      kw_d = '0; pend_d = '0;
    end else if (!halt_q) begin
      unique case (mode_q)
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            if (tlen_q < 16'd6) kw_d = {kw_q[39:0], b};
            else kwlong_d = 1'b1;
            tlen_d = linc(tlen_q);
          end else begin
            t = '0; t.kind = id_kind; t.bval = id_bool; t.len = tlen_q;
            t.line = p16(tline_q); t.col = p16(tcol_q); res[0] = t; cnt = 2'd1;
            repro = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(b)) begin
            if (!ovf_q && acc_sum <= (AccW+4)'(IntLim)) acc_d = acc_sum[AccW-1:0];
            else begin acc_d = IntLim; ovf_d = 1'b1; end
            tlen_d = linc(tlen_q);
          end else if (b == 8'h2e) mode_d = M_INT_DOT;
          else begin
            t = '0; t.kind = K_INT; t.ival = acc_out; t.ovf = ovf_q; t.len = tlen_q;
            t.line = p16(tline_q); t.col = p16(tcol_q); res[0] = t; cnt = 2'd1;
            repro = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (is_digit(b)) begin
            mode_d = M_DECIMAL; tlen_d = linc(linc(tlen_q));
          end else begin
            t = '0; t.kind = K_INT; t.ival = acc_out; t.ovf = ovf_q; t.len = tlen_q;
            t.line = p16(tline_q); t.col = p16(tcol_q); res[0] = t;
            t = '0; t.kind = K_ERROR; t.err = E_BADCHAR; t.line = p16(line_q);
            t.col = p16(col_q); res[1] = t; cnt = 2'd2;
            halt_d = 1'b1; mode_d = M_IDLE;
          end
        end
        M_DECIMAL: begin
          if (is_digit(b)) tlen_d = linc(tlen_q);
          else begin
            t = '0; t.kind = K_DEC; t.len = tlen_q;
            t.line = p16(tline_q); t.col = p16(tcol_q); res[0] = t; cnt = 2'd1;
            repro = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == 8'h2f) mode_d = M_COMMENT;
          else begin
            t = '0; t.kind = K_SLASH; t.len = 16'd1;
            t.line = p16(tline_q); t.col = p16(tcol_q); res[0] = t; cnt = 2'd1;
            repro = 1'b1;
          end
        end
        M_COMMENT: if (b == 8'h0a) mode_d = M_IDLE;
        M_OP: begin
          t = '0; t.line = p16(tline_q); t.col = p16(tcol_q);
          if (b == 8'h3d) begin
            t.kind = pend_q[KindW-1:0] + 1'b1; t.len = 16'd2; mode_d = M_IDLE;
          end else begin
            t.kind = pend_q[KindW-1:0]; t.len = 16'd1; repro = 1'b1;
          end
          res[0] = t; cnt = 2'd1;
        end
        M_CHAR_OPEN: begin
          tlen_d = linc(tlen_q);
          if (b == 8'h5c) mode_d = M_CHAR_ESC;
          else begin pend_d = b; mode_d = M_CHAR_CLOSE; end
        end
        M_CHAR_ESC: begin
          tlen_d = linc(tlen_q); pend_d = unescape(b); mode_d = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          t = '0; t.line = p16(tline_q); t.col = p16(tcol_q);
          if (b == 8'h27) begin
            tlen_d = linc(tlen_q);
            t.kind = K_CHAR; t.len = linc(tlen_q); t.byte_v = pend_q; mode_d = M_IDLE;
          end else begin
            t.kind = K_ERROR; t.err = E_NOQUOTE; t.line = p16(line_q); t.col = p16(col_q);
            halt_d = 1'b1; mode_d = M_IDLE;
          end
          res[0] = t; cnt = 2'd1;
        end
        M_STRING: begin
          tlen_d = linc(tlen_q);
          t = '0; t.line = p16(tline_q); t.col = p16(tcol_q);
          if (b == 8'h22) begin
            t.kind = K_STR; t.len = linc(tlen_q); mode_d = M_IDLE; res[0] = t; cnt = 2'd1;
          end else if (b == 8'h5c) mode_d = M_STRING_ESC;
          else begin t.kind = K_SBYTE; t.byte_v = b; res[0] = t; cnt = 2'd1; end
        end
        M_STRING_ESC: begin
          tlen_d = linc(tlen_q);
          t = '0; t.line = p16(tline_q); t.col = p16(tcol_q);
          t.kind = K_SBYTE; t.byte_v = unescape(b); res[0] = t; cnt = 2'd1;
          mode_d = M_STRING;
        end
        default: repro = 1'b1;
      endcase

      if (repro) begin
        mode_d = M_IDLE;
        t = '0; t.line = p16(line_q); t.col = p16(col_q); t.len = 16'd1;
        emitted = 1'b1;
        priority if (b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a) emitted = 1'b0;
        else if (is_alpha(b)) begin
          emitted = 1'b0; mode_d = M_IDENT; kw_d = {40'd0, b}; kwlong_d = 1'b0;
        end else if (is_digit(b)) begin
          emitted = 1'b0; mode_d = M_INT; ovf_d = 1'b0; acc_d = AccW'(b - 8'h30);
        end else if (b == 8'h2f) begin emitted = 1'b0; mode_d = M_SLASH; end
        else if (b == 8'h27) begin emitted = 1'b0; mode_d = M_CHAR_OPEN; end
        else if (b == 8'h22) begin emitted = 1'b0; mode_d = M_STRING; end
        else if (b == 8'h3d) begin emitted = 1'b0; mode_d = M_OP; pend_d = 8'(K_ASSIGN); end
        else if (b == 8'h21) begin emitted = 1'b0; mode_d = M_OP; pend_d = 8'(K_NOT); end
        else if (b == 8'h3c) begin emitted = 1'b0; mode_d = M_OP; pend_d = 8'(K_LT); end
        else if (b == 8'h3e) begin emitted = 1'b0; mode_d = M_OP; pend_d = 8'(K_GT); end
        else if (b == 8'h7b) t.kind = K_LBRACE;
        else if (b == 8'h7d) t.kind = K_RBRACE;
        else if (b == 8'h2b) t.kind = K_PLUS;
        else if (b == 8'h2d) t.kind = K_MINUS;
        else if (b == 8'h2a) t.kind = K_STAR;
        else if (b == 8'h28) t.kind = K_LPAR;
        else if (b == 8'h29) t.kind = K_RPAR;
        else if (b == 8'h5b) t.kind = K_LBRK;
        else if (b == 8'h5d) t.kind = K_RBRK;
        else if (b == 8'h2c) t.kind = K_COMMA;
        else if (b == 8'h3b) t.kind = K_SEMI;
        else if (b == 8'h3a) t.kind = K_COLON;
        else begin
          t.kind = K_ERROR; t.err = E_BADCHAR; t.len = '0;
          t.col = p16(pinc(col_q)); halt_d = 1'b1;
        end
        if (!(b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a) && t.kind != K_ERROR) begin
          tline_d = line_q; tcol_d = col_q; tlen_d = 16'd1;
        end
        if (emitted) begin res[cnt] = t; cnt = cnt + 2'd1; end
      end

      if (!halt_d) begin
        if (b == 8'h0a) begin line_d = pinc(line_q); col_d = PosOne; end
        else col_d = pinc(col_q);
      end
    end

    out_d.n = cnt;
    out_d.r[0] = res[0];
    out_d.r[1] = res[1];
    out_d.r[2] = res[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; line_q <= PosOne; col_q <= PosOne; tline_q <= PosOne;
      tcol_q <= PosOne; tlen_q <= '0; acc_q <= '0; ovf_q <= 1'b0; kwlong_q <= 1'b0;
      halt_q <= 1'b0; kw_q <= '0; pend_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d; line_q <= line_d; col_q <= col_d; tline_q <= tline_d;
      tcol_q <= tcol_d; tlen_q <= tlen_d; acc_q <= acc_d; ovf_q <= ovf_d;
      kwlong_q <= kwlong_d; halt_q <= halt_d; kw_q <= kw_d; pend_q <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_queue: two-entry bundle queue
// Decouples the scanner from the result serialiser.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_valid_i,
  output logic         wr_ready_o,
  input  wire bundle_t wr_data_i,
  output logic         rd_valid_o,
  input  wire logic    rd_ready_i,
  output bundle_t      rd_data_o
);

  bundle_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_back: result serialiser
// Sends the results of one bundle one per transaction, marking the last.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    b_valid_i,
  output logic         b_ready_o,
  input  wire bundle_t b_data_i,
  output logic         m_valid_o,
  input  wire logic    m_ready_i,
  output tok_t         m_tok_o,
  output logic         m_last_o
);

  logic [1:0] idx_q;
  logic last;

  assign last      = (idx_q + 2'd1 == b_data_i.n);
  assign m_valid_o = b_valid_i;
  assign m_tok_o   = b_data_i.r[idx_q];
  assign m_last_o  = last;
  assign b_ready_o = m_ready_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 2'd0;
    else if (b_valid_i && m_ready_i) idx_q <= last ? 2'd0 : idx_q + 2'd1;
  end

endmodule
`default_nettype wire

// ----- rtl/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer
// Bytes in, tokens out with position, length and literal values.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | tlast
//  s_axis  | in  | text_byte[7:0]                | command     | -
//  m_axis  | out | token fields (see port below) | error_code  | last
//
// A byte is taken every cycle while the queue has room; the scanner decides
// in the same cycle and writes up to three results as one bundle, if any.
// A byte's results leave from the queue register, after any earlier bundles.
// The output side sends one result per cycle while m_axis_tready is high, so a
// byte giving n results needs n transfers; the two-entry queue absorbs bursts.
// Reset puts the scanner between tokens at line 1, column 1, queue empty.
// Either side may stall freely; nothing is lost.
// ----------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned INT_BITS      = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // text_byte
  input  wire logic         s_axis_tuser,   // command
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // token_kind[5:0], start_line[21:6], start_column[37:22], int_val[68:38],
  // value_overflow[69], byte_value[77:70], bool_val[78], lexeme_length[94:79]
  output logic [95:0]       m_axis_tdata,
  output logic [2:0]        m_axis_tuser,   // error_code
  output logic              m_axis_tlast
);

  bundle_t fq_data, qb_data;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  tok_t tok;

  stt_front #(.POSITION_BITS(POSITION_BITS), .INT_BITS(INT_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .byte_i(s_axis_tdata),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_data_o(fq_data)
  );

  stt_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_data),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_data_o(qb_data)
  );

  stt_back u_back (
    .clk_i, .rst_ni,
    .b_valid_i(qb_valid), .b_ready_o(qb_ready), .b_data_i(qb_data),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_tok_o(tok), .m_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, tok.len, tok.bval, tok.byte_v, tok.ovf, tok.ival,
                         tok.col, tok.line, tok.kind};
  assign m_axis_tuser = tok.err;

endmodule
`default_nettype wire

// ----- rtl/stt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_checker: port-level checks
// Watches the top level's streams.
// ----------------------------------------------------------------------------
module stt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [95:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 3'd0 |-> m_axis_tdata[5:0] == 6'd34)
    else $error("error code on non-error token");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:0] == 6'd0 |-> m_axis_tlast)
    else $error("end token not last");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5:0] <= 6'd34 && m_axis_tdata[95] == 1'b0)
    else $error("bad token kind");

endmodule

bind source_text_tokenizer stt_checker u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);
`default_nettype wire
